// ===== src/vbcn_pkg.sv =====
package vbcn_pkg;

	localparam int COORD_BITS = 32;
	localparam int FRAC_BITS  = 16;
	localparam int QUO_BITS   = FRAC_BITS + 1;
	localparam int OUT_BITS   = FRAC_BITS + 2;
	localparam int CNT_BITS   = $clog2(FRAC_BITS + 1);

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic        [COORD_BITS-1:0] ukey_t;
	typedef logic signed [OUT_BITS-1:0]   norm_t;

	localparam ukey_t COORD_SIGN = {1'b1, {(COORD_BITS-1){1'b0}}};
	localparam logic [QUO_BITS-1:0] QUO_ONE = {1'b1, {FRAC_BITS{1'b0}}};

	// Per-cycle commands from the sequencer to every axis lane
	typedef struct packed {
		logic seed;
		logic widen;
		logic load;
		logic prep;
		logic step;
		logic round;
	} lane_ctrl_t;

	// Map a signed coordinate to an order-preserving unsigned key
	function automatic ukey_t okey(input coord_t v);
		okey = ukey_t'(v) ^ COORD_SIGN;
	endfunction

endpackage

// ===== src/vbcn_lane.sv =====
module vbcn_lane (
	input  logic                 clk,
	input  logic                 arst_n,
	input  vbcn_pkg::lane_ctrl_t ctrl,
	input  vbcn_pkg::coord_t     coord,
	input  vbcn_pkg::ukey_t      divisor,
	output vbcn_pkg::ukey_t      extent,
	output vbcn_pkg::norm_t      norm
);
	import vbcn_pkg::*;

	coord_t lo_q, hi_q, v_q;
	ukey_t  r_q;
	logic [QUO_BITS-1:0] q_q;
	logic   sat_q, neg_q;

	ukey_t  kc, kl, kh, kv, e, k, p, m_pre;
	logic   below, above, out_sat, in_neg, sat_pre, neg_pre;
	logic [COORD_BITS:0] k2, dx, e2, t, t_abs, r2;
	logic   ge;
	logic [QUO_BITS-1:0] mag;

	// Key compares for bounds and the box extent
	always_comb begin
		kc = okey(coord);
		kl = okey(lo_q);
		kh = okey(hi_q);
		kv = okey(v_q);
		e  = kh - kl;
	end

	assign extent = e;

	// Reduce the centered offset to a magnitude below the divisor, or flag saturation
	always_comb begin
		below = kv < kl;
		above = kv > kh;
		dx    = {1'b0, divisor};
		e2    = {1'b0, e};
		k     = below ? (kl - kv) : (kv - kh);
		k2    = {k, 1'b0};
		p     = kv - kl;
		t     = {p, 1'b0} - e2;
		in_neg = t[COORD_BITS];
		t_abs = in_neg ? (-t) : t;
		out_sat = (k2 >= dx) || (e2 >= dx - k2);
		if (below || above) begin
			neg_pre = below;
			sat_pre = out_sat;
			m_pre   = out_sat ? '0 : COORD_BITS'(k2 + e2);
		end else begin
			neg_pre = in_neg;
			m_pre   = t_abs[COORD_BITS-1:0];
			sat_pre = m_pre >= divisor;
		end
	end

	// One restoring quotient bit per step
	always_comb begin
		r2 = {r_q, 1'b0};
		ge = r2 >= dx;
	end

	// Hold bounds, vertex and divider state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q  <= '0;
			hi_q  <= '0;
			v_q   <= '0;
			r_q   <= '0;
			q_q   <= '0;
			sat_q <= 1'b0;
			neg_q <= 1'b0;
		end else begin
			if (ctrl.seed) begin
				lo_q <= coord;
				hi_q <= coord;
			end else if (ctrl.widen) begin
				if (kc < kl) lo_q <= coord;
				if (kc > kh) hi_q <= coord;
			end
			if (ctrl.load) v_q <= coord;
			if (ctrl.prep) begin
				r_q   <= m_pre;
				q_q   <= '0;
				sat_q <= sat_pre;
				neg_q <= neg_pre;
			end else if (ctrl.step) begin
				r_q <= ge ? COORD_BITS'(r2 - dx) : COORD_BITS'(r2);
				q_q <= {q_q[QUO_BITS-2:0], ge};
			end else if (ctrl.round) begin
				q_q <= q_q + QUO_BITS'(ge);
			end
		end
	end

	// Apply saturation and sign
	always_comb begin
		mag  = sat_q ? QUO_ONE : q_q;
		norm = neg_q ? norm_t'(-{1'b0, mag}) : norm_t'({1'b0, mag});
	end

endmodule

// ===== src/vbcn_merge.sv =====
module vbcn_merge (
	input  logic            clk,
	input  logic            arst_n,
	input  vbcn_pkg::ukey_t ext_x,
	input  vbcn_pkg::ukey_t ext_y,
	input  vbcn_pkg::ukey_t ext_z,
	output vbcn_pkg::ukey_t ext_max,
	input  logic            load,
	input  logic            degen,
	input  logic            last,
	input  vbcn_pkg::norm_t nx,
	input  vbcn_pkg::norm_t ny,
	input  vbcn_pkg::norm_t nz,
	output logic            out_free,
	output logic            out_valid,
	input  logic            out_stall,
	output vbcn_pkg::norm_t x_norm,
	output vbcn_pkg::norm_t y_norm,
	output vbcn_pkg::norm_t z_norm,
	output logic            degenerate,
	output logic            last_out
);
	import vbcn_pkg::*;

	ukey_t m_xy;

	// Pick the largest extent of the three lanes
	always_comb begin
		m_xy    = (ext_y > ext_x) ? ext_y : ext_x;
		ext_max = (ext_z > m_xy) ? ext_z : m_xy;
	end

	assign out_free = !out_valid || !out_stall;

	// Hold the result until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	// Load payload, zeroed when degenerate
	always_ff @(posedge clk) begin
		if (load) begin
			x_norm     <= degen ? '0 : nx;
			y_norm     <= degen ? '0 : ny;
			z_norm     <= degen ? '0 : nz;
			degenerate <= degen;
			last_out   <= last;
		end
	end

endmodule

// ===== src/vertex_bbox_center_normalize.sv =====
// Measuring vertex (func 0): accepted every cycle; after the last one of a pass, input
// stalls in S_EXT while the bounds are frozen. Transform vertex (func 1): S_PREP, then
// the one-bit-per-cycle restoring divider in each axis lane; input stalls until S_OUT
// hands the result on. Degenerate transform vertex: skips the divider, goes to S_OUT.
// Asynchronous active-low reset clears control: bounds not ready, next vertex seeds.
module vertex_bbox_center_normalize (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             func,
	input  vbcn_pkg::coord_t x_coord,
	input  vbcn_pkg::coord_t y_coord,
	input  vbcn_pkg::coord_t z_coord,
	input  logic             last_in,
	output logic             out_valid,
	input  logic             out_stall,
	output vbcn_pkg::norm_t  x_norm,
	output vbcn_pkg::norm_t  y_norm,
	output vbcn_pkg::norm_t  z_norm,
	output logic             degenerate,
	output logic             last_out
);
	import vbcn_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_EXT, S_PREP, S_DIV, S_OUT} state_t;

	state_t state_q;
	logic   first_pending_q, bounds_ready_q, degen_q, last_q;
	ukey_t  div_q;
	logic [CNT_BITS-1:0] cnt_q;

	lane_ctrl_t ctrl;
	ukey_t  ext_x, ext_y, ext_z, ext_max;
	norm_t  nx, ny, nz;
	logic   accept, out_free, out_load, cnt_end;

	assign in_stall = state_q != S_IDLE;
	assign accept   = in_valid && !in_stall;
	assign cnt_end  = cnt_q == CNT_BITS'(FRAC_BITS);
	assign out_load = (state_q == S_OUT) && out_free;

	// Decode lane commands
	always_comb begin
		ctrl.seed  = accept && !func && first_pending_q;
		ctrl.widen = accept && !func && !first_pending_q;
		ctrl.load  = accept && func;
		ctrl.prep  = state_q == S_PREP;
		ctrl.step  = (state_q == S_DIV) && !cnt_end;
		ctrl.round = (state_q == S_DIV) && cnt_end;
	end

	// Sequence passes, divider steps and result hand-off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			first_pending_q <= 1'b1;
			bounds_ready_q  <= 1'b0;
			div_q           <= '0;
			degen_q         <= 1'b0;
			last_q          <= 1'b0;
			cnt_q           <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && !func) begin
						if (first_pending_q) bounds_ready_q <= 1'b0;
						first_pending_q <= last_in;
						if (last_in) state_q <= S_EXT;
					end else if (accept) begin
						last_q <= last_in;
						if (!bounds_ready_q || div_q == '0) begin
							degen_q <= 1'b1;
							state_q <= S_OUT;
						end else begin
							degen_q <= 1'b0;
							state_q <= S_PREP;
						end
					end
				end
				S_EXT: begin
					div_q          <= ext_max;
					bounds_ready_q <= 1'b1;
					state_q        <= S_IDLE;
				end
				S_PREP: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_end) state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	vbcn_lane u_lane_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.coord   (x_coord),
		.divisor (div_q),
		.extent  (ext_x),
		.norm    (nx)
	);

	vbcn_lane u_lane_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.coord   (y_coord),
		.divisor (div_q),
		.extent  (ext_y),
		.norm    (ny)
	);

	vbcn_lane u_lane_z (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.coord   (z_coord),
		.divisor (div_q),
		.extent  (ext_z),
		.norm    (nz)
	);

	vbcn_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.ext_x      (ext_x),
		.ext_y      (ext_y),
		.ext_z      (ext_z),
		.ext_max    (ext_max),
		.load       (out_load),
		.degen      (degen_q),
		.last       (last_q),
		.nx         (nx),
		.ny         (ny),
		.nz         (nz),
		.out_free   (out_free),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.x_norm     (x_norm),
		.y_norm     (y_norm),
		.z_norm     (z_norm),
		.degenerate (degenerate),
		.last_out   (last_out)
	);

`ifndef SYNTHESIS
	a_div_needs_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PREP || state_q == S_DIV) |-> (bounds_ready_q && div_q != '0))
		else $error("divider running without valid bounds");

	a_good_transform_divides: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && func && bounds_ready_q && div_q != '0) |=> (state_q == S_PREP))
		else $error("transform vertex skipped the divider");

	a_ext_sets_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXT) |=> (bounds_ready_q && first_pending_q))
		else $error("closing a measuring pass did not freeze bounds");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_load && out_valid && out_stall))
		else $error("result overwritten while stalled");
`endif

endmodule
